// ===== rtl/core/fixed_partition_fit_allocator_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_MACROS_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPFA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpfa: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FPFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpfa: next-cycle check failed");

`endif

// ===== rtl/core/fpfa_pkg.sv =====
package fpfa_pkg;

    localparam int FPFA_MAX_PARTITIONS = 16;
    localparam int FPFA_SIZE_BITS      = 16;

    localparam int SLOT_W    = 4;
    localparam int AMOUNT_W  = 16;
    localparam int PID_W     = 8;
    localparam int POLICY_W  = 2;
    localparam int COUNT_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [POLICY_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] FIT_WORST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARTITION_COUNT = 2'd1;

    localparam logic [POLICY_W-1:0] POLICY_RESET = FIT_FIRST;
    localparam logic [COUNT_W-1:0]  COUNT_RESET  = 5'd16;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_PLACE = 1'b1;

endpackage

// ===== rtl/core/fpfa_table.sv =====
module fpfa_table #(
    parameter int MAX_PARTITIONS = fpfa_pkg::FPFA_MAX_PARTITIONS,
    parameter int SIZE_BITS      = fpfa_pkg::FPFA_SIZE_BITS,
    parameter int IDX_W          = $clog2(MAX_PARTITIONS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic [IDX_W-1:0]     i_load_idx,
    input  logic [SIZE_BITS-1:0] i_load_size,
    input  logic                 i_take,
    input  logic [IDX_W-1:0]     i_take_idx,
    input  logic [IDX_W-1:0]     i_rd_idx,
    output logic [SIZE_BITS-1:0] o_rd_size,
    output logic                 o_rd_free
);
    import fpfa_pkg::*;

    logic [SIZE_BITS-1:0]      r_mem [MAX_PARTITIONS];
    logic [SIZE_BITS-1:0]      r_rd_raw;
    logic [MAX_PARTITIONS-1:0] r_loaded;
    logic [MAX_PARTITIONS-1:0] r_taken;
    logic                      r_rd_loaded;
    logic                      r_rd_free;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mem[i_load_idx] <= i_load_size;
        end
        r_rd_raw <= r_mem[i_rd_idx];
    end

    // A slot never loaded since reset reads as size zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded    <= '0;
            r_taken     <= '0;
            r_rd_loaded <= 1'b0;
            r_rd_free   <= 1'b0;
        end else begin
            if (i_load) begin
                r_loaded[i_load_idx] <= 1'b1;
                r_taken[i_load_idx]  <= 1'b0;
            end else if (i_take) begin
                r_taken[i_take_idx] <= 1'b1;
            end
            r_rd_loaded <= r_loaded[i_rd_idx];
            r_rd_free   <= !r_taken[i_rd_idx];
        end
    end

    assign o_rd_size = r_rd_loaded ? r_rd_raw : '0;
    assign o_rd_free = r_rd_free;

endmodule

// ===== rtl/core/fixed_partition_fit_allocator.sv =====
// A load beat gives no result. A placement holds off new beats until its result is registered.
// It scans slots 0..N-1, one per cycle through one comparator, N being the saturated partition
// count (fewer under first fit); each slot is read from the registered table, then compared.
// The result is registered as the done state is left, held while the last result is stalled.
// Synchronous active-low reset sets first fit and count 16 and clears the sequencer and all
// loaded and taken marks, so unloaded slots read as free partitions of size zero.
`include "fixed_partition_fit_allocator_macros.svh"

module fixed_partition_fit_allocator #(
    parameter int MAX_PARTITIONS = fpfa_pkg::FPFA_MAX_PARTITIONS,
    parameter int SIZE_BITS      = fpfa_pkg::FPFA_SIZE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fpfa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fpfa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_req_type,
    input  logic [fpfa_pkg::SLOT_W-1:0]     i_slot,
    input  logic [fpfa_pkg::AMOUNT_W-1:0]   i_amount,
    input  logic [fpfa_pkg::PID_W-1:0]      i_process_id,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_placed,
    output logic [fpfa_pkg::SLOT_W-1:0]     o_chosen_slot,
    output logic [fpfa_pkg::AMOUNT_W-1:0]   o_leftover,
    output logic [fpfa_pkg::PID_W-1:0]      o_owner_id
);
    import fpfa_pkg::*;

    localparam int IDX_W  = $clog2(MAX_PARTITIONS);
    localparam int CNT_W  = $clog2(MAX_PARTITIONS + 1);
    localparam int KW     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int LW     = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam int CMP_W  = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [POLICY_W-1:0]   r_fit_policy;
    logic [COUNT_W-1:0]    r_partition_count;
    logic [AMOUNT_W-1:0]   r_amount;
    logic [PID_W-1:0]      r_pid;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_ri;
    logic                  r_cmp_vld;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic                  r_found;
    logic [IDX_W-1:0]      r_best_idx;
    logic [SIZE_BITS-1:0]  r_best_size;
    logic                  r_out_valid;
    logic                  r_placed;
    logic [SLOT_W-1:0]     r_chosen;
    logic [AMOUNT_W-1:0]   r_leftover;
    logic [PID_W-1:0]      r_owner;

    logic                  in_acc;
    logic                  place_acc;
    logic                  load_acc;
    logic                  load_en;
    logic [CNT_W-1:0]      count_sat;
    logic                  issue;
    logic [SIZE_BITS-1:0]  rd_size;
    logic                  rd_free;
    logic                  policy_first;
    logic                  fits;
    logic                  better;
    logic                  take_cand;
    logic                  last_slot;
    logic                  finish;
    logic                  out_room;
    logic                  commit;
    logic [CMP_W-1:0]      diff;
    logic                  out_zero;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign place_acc   = in_acc && (i_req_type == REQ_PLACE);
    assign load_acc    = in_acc && (i_req_type == REQ_LOAD);
    assign load_en     = load_acc && (LW'(i_slot) < LW'(MAX_PARTITIONS));

    assign count_sat = (KW'(r_partition_count) > KW'(MAX_PARTITIONS))
                       ? CNT_W'(MAX_PARTITIONS) : CNT_W'(r_partition_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_policy      <= POLICY_RESET;
            r_partition_count <= COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_FIT_POLICY: begin
                    r_fit_policy <= i_cfg_data[POLICY_W-1:0];
                end
                REG_PARTITION_COUNT: begin
                    r_partition_count <= i_cfg_data[COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    fpfa_table #(
        .MAX_PARTITIONS (MAX_PARTITIONS),
        .SIZE_BITS      (SIZE_BITS),
        .IDX_W          (IDX_W)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load_en),
        .i_load_idx  (IDX_W'(i_slot)),
        .i_load_size (SIZE_BITS'(i_amount)),
        .i_take      (commit && r_found),
        .i_take_idx  (r_best_idx),
        .i_rd_idx    (r_ri[IDX_W-1:0]),
        .o_rd_size   (rd_size),
        .o_rd_free   (rd_free)
    );

    // Policy code three behaves as first fit.
    assign policy_first = (r_fit_policy != FIT_BEST) && (r_fit_policy != FIT_WORST);

    assign issue = (r_ri < r_count);
    assign fits  = rd_free && (CMP_W'(rd_size) >= CMP_W'(r_amount));

    always_comb begin
        case (r_fit_policy)
            FIT_BEST:  better = (rd_size < r_best_size);
            FIT_WORST: better = (rd_size > r_best_size);
            default:   better = 1'b0;
        endcase
    end

    assign take_cand = r_cmp_vld && fits && (!r_found || better);
    assign last_slot = (CNT_W'(r_cmp_idx) == (r_count - CNT_W'(1)));
    assign finish    = r_cmp_vld && (last_slot || (fits && policy_first));

    assign out_room = !r_out_valid || !i_out_stall;
    assign commit   = (r_state == S_DONE) && out_room;
    assign diff     = CMP_W'(r_best_size) - CMP_W'(r_amount);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (place_acc) begin
                    n_state = (count_sat == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (finish) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_room) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ri        <= '0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_ri      <= '0;
                r_cmp_vld <= 1'b0;
                r_found   <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_cmp_vld <= issue && !finish;
                if (issue) begin
                    r_ri <= r_ri + CNT_W'(1);
                end
                if (take_cand) begin
                    r_found <= 1'b1;
                end
            end else begin
                r_cmp_vld <= 1'b0;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_amount <= i_amount;
            r_pid    <= i_process_id;
            r_count  <= count_sat;
        end
        r_cmp_idx <= r_ri[IDX_W-1:0];
        if (take_cand && (r_state == S_SCAN)) begin
            r_best_idx  <= r_cmp_idx;
            r_best_size <= rd_size;
        end
        if (commit) begin
            r_placed   <= r_found;
            r_chosen   <= r_found ? SLOT_W'(r_best_idx) : '0;
            r_leftover <= r_found ? diff[AMOUNT_W-1:0] : '0;
            r_owner    <= r_pid;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_placed      = r_placed;
    assign o_chosen_slot = r_chosen;
    assign o_leftover    = r_leftover;
    assign o_owner_id    = r_owner;

    assign out_zero = (r_chosen == '0) && (r_leftover == '0);

    `FPFA_ASSERT_SAME(a_unplaced_zero, i_clk, i_rst_n, r_out_valid && !r_placed, out_zero)
    `FPFA_ASSERT_SAME(a_scan_bound, i_clk, i_rst_n, r_state == S_SCAN, r_ri <= r_count)
    `FPFA_ASSERT_NEXT(a_place_starts, i_clk, i_rst_n, place_acc, r_state != S_IDLE)
    `FPFA_ASSERT_NEXT(a_result_from_done, i_clk, i_rst_n, !r_out_valid && !commit, !r_out_valid)
    `FPFA_ASSERT_NEXT(a_load_no_result, i_clk, i_rst_n, load_acc, r_state == S_IDLE)

endmodule

// ===== verif/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fpfa_pkg::*;

    // Policy code 3 is unused by the block and must behave as first fit.
    localparam logic [POLICY_W-1:0]  FIT_SPARE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_ITEMS   = 150;
    localparam int IDLE_PERCENT  = 28;

    typedef struct packed {
        logic                placed;
        logic [SLOT_W-1:0]   slot;
        logic [AMOUNT_W-1:0] leftover;
        logic [PID_W-1:0]    owner;
    } t_placement;

    class t_scoreboard;
        logic [POLICY_W-1:0]       policy;
        logic [COUNT_W-1:0]        slots_in_use;
        logic [FPFA_SIZE_BITS-1:0] part_size [FPFA_MAX_PARTITIONS];
        bit                        taken [FPFA_MAX_PARTITIONS];
        t_placement                pending_placements [$];
        int                        errors;

        function new();
            policy       = POLICY_RESET;
            slots_in_use = COUNT_RESET;
            errors       = 0;
            foreach (part_size[i]) begin
                part_size[i] = '0;
                taken[i]     = 1'b0;
            end
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_FIT_POLICY: begin
                    policy = val[POLICY_W-1:0];
                end
                REG_PARTITION_COUNT: begin
                    slots_in_use = val[COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function int pending();
            return pending_placements.size();
        endfunction

        // Loads update the table; placements work out the slot and queue the result.
        function void note_request(input logic req, input logic [SLOT_W-1:0] slot,
                                   input logic [AMOUNT_W-1:0] amount,
                                   input logic [PID_W-1:0] pid);
            int         limit;
            int         pick;
            bit         found;
            t_placement want;
            if (req == REQ_LOAD) begin
                part_size[slot] = amount;
                taken[slot]     = 1'b0;
                return;
            end
            limit = (slots_in_use > FPFA_MAX_PARTITIONS) ? FPFA_MAX_PARTITIONS
                                                         : int'(slots_in_use);
            found = 1'b0;
            pick  = 0;
            for (int i = 0; i < limit; i++) begin
                if (taken[i] || part_size[i] < amount)
                    continue;
                if (!found) begin
                    found = 1'b1;
                    pick  = i;
                    if (policy == FIT_FIRST || policy == FIT_SPARE)
                        break;
                end else if (policy == FIT_BEST && part_size[i] < part_size[pick]) begin
                    pick = i;
                end else if (policy == FIT_WORST && part_size[i] > part_size[pick]) begin
                    pick = i;
                end
            end
            want.placed   = found;
            want.slot     = found ? pick[SLOT_W-1:0] : '0;
            want.leftover = found ? part_size[pick] - amount : '0;
            want.owner    = pid;
            if (found)
                taken[pick] = 1'b1;
            pending_placements.push_back(want);
        endfunction

        task report_mismatch(input string msg);
            errors++;
            $display("[tb] mismatch: %s", msg);
        endtask

        task check_result(input t_placement got);
            t_placement want;
            if (pending_placements.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: slot %0d owner %0d",
                                          got.slot, got.owner));
                return;
            end
            want = pending_placements.pop_front();
            if (got.placed !== want.placed || got.slot !== want.slot ||
                got.leftover !== want.leftover || got.owner !== want.owner) begin
                report_mismatch($sformatf(
                    "got placed %0b slot %0d leftover %0d owner %0d, want %0b %0d %0d %0d",
                    got.placed, got.slot, got.leftover, got.owner,
                    want.placed, want.slot, want.leftover, want.owner));
            end
        endtask
    endclass

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_valid  = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  i_in_valid   = 1'b0;
    logic                  o_in_stall;
    logic                  i_req_type   = 1'b0;
    logic [SLOT_W-1:0]     i_slot       = '0;
    logic [AMOUNT_W-1:0]   i_amount     = '0;
    logic [PID_W-1:0]      i_process_id = 8'd1;
    logic                  o_out_valid;
    logic                  i_out_stall  = 1'b0;
    logic                  o_placed;
    logic [SLOT_W-1:0]     o_chosen_slot;
    logic [AMOUNT_W-1:0]   o_leftover;
    logic [PID_W-1:0]      o_owner_id;

    t_scoreboard         sb;
    bit                  calm = 1'b0;
    int unsigned         cycles = 0;

    fixed_partition_fit_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_slot        (i_slot),
        .i_amount      (i_amount),
        .i_process_id  (i_process_id),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_placed      (o_placed),
        .o_chosen_slot (o_chosen_slot),
        .o_leftover    (o_leftover),
        .o_owner_id    (o_owner_id)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[fixed_partition_fit_allocator] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // Values read here are the ones in place before the edge.
    always @(posedge i_clk) begin
        t_placement got;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_request(i_req_type, i_slot, i_amount, i_process_id);
            if (o_out_valid && !i_out_stall) begin
                got.placed   = o_placed;
                got.slot     = o_chosen_slot;
                got.leftover = o_leftover;
                got.owner    = o_owner_id;
                sb.check_result(got);
            end
        end
    end

    task automatic send_item(input logic req, input logic [SLOT_W-1:0] slot,
                             input logic [AMOUNT_W-1:0] amount,
                             input logic [PID_W-1:0] pid);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_slot       <= slot;
        i_amount     <= amount;
        i_process_id <= pid;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic load(input logic [SLOT_W-1:0] slot, input logic [AMOUNT_W-1:0] size);
        send_item(REQ_LOAD, slot, size, PID_W'($urandom_range(1, 255)));
    endtask

    task automatic place(input logic [AMOUNT_W-1:0] amount, input logic [PID_W-1:0] pid);
        send_item(REQ_PLACE, SLOT_W'($urandom_range(0, 15)), amount, pid);
    endtask

    // Leaves valid high so that back-to-back register beats need no re-raise.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] policy_data,
                              input logic [CFG_DATA_W-1:0] count);
        write_reg(REG_FIT_POLICY, policy_data);
        write_reg(REG_PARTITION_COUNT, count);
        i_cfg_valid <= 1'b0;
    endtask

    // A load produces no result, so wait past the longest scan once the queue is empty.
    // The first edge lets the monitor note the last accepted beat before the queue is read.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [AMOUNT_W-1:0] pick_size(input int unsigned scale);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        if (roll < 10)
            return '1;
        return AMOUNT_W'($urandom_range(0, scale));
    endfunction

    task automatic run_phase();
        int unsigned scale;
        int          offset;
        int          roll;
        scale  = ($urandom_range(0, 1) == 0) ? 255 : 65535;
        offset = $urandom_range(0, 15);
        // Fill the whole table first so requests have something to fit into.
        for (int i = 0; i < FPFA_MAX_PARTITIONS; i++)
            load(SLOT_W'(i + offset), pick_size(scale));
        for (int n = FPFA_MAX_PARTITIONS; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
                load(SLOT_W'($urandom_range(0, 15)), pick_size(scale));
            else if (roll < 36)
                place('0, PID_W'($urandom_range(1, 255)));
            else if (roll < 42)
                place(AMOUNT_W'($urandom_range(0, 65535)), PID_W'($urandom_range(1, 255)));
            else
                place(AMOUNT_W'($urandom_range(0, scale)), PID_W'($urandom_range(1, 255)));
        end
    endtask

    initial begin
        int                    roll;
        logic [CFG_DATA_W-1:0] policy_data;
        logic [CFG_DATA_W-1:0] count;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Right after reset every slot is a free partition of size zero.
        place(16'd0, 8'd1);
        place(16'd1, 8'd255);
        load(4'd0, 16'd100);
        load(4'd1, 16'd40);
        load(4'd2, 16'hFFFF);
        load(4'd3, 16'd0);
        load(4'd15, 16'd200);
        place(16'd50, 8'd2);
        place(16'hFFFF, 8'd3);
        place(16'hFFFF, 8'd4);

        settle();
        write_reg(REG_SPARE_A, 5'd31);
        write_reg(REG_SPARE_B, 5'd0);
        set_config(FIT_BEST, 5'd16);
        load(4'd0, 16'd100);
        load(4'd2, 16'hFFFF);
        place(16'd30, 8'd5);
        place(16'd30, 8'd6);

        settle();
        set_config(FIT_WORST, 5'd16);
        place(16'd10, 8'd7);
        place(16'd0, 8'd8);

        settle();
        set_config({3'b111, FIT_SPARE}, 5'd31);
        place(16'd0, 8'd9);

        settle();
        set_config(FIT_FIRST, 5'd0);
        place(16'd0, 8'd10);

        settle();
        set_config(FIT_WORST, 5'd1);
        load(4'd0, 16'h8000);
        place(16'h7FFF, 8'd11);
        place(16'd0, 8'd12);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            calm = (p == 5 || p == 6);
            roll = $urandom_range(0, 9);
            if (roll == 0)
                count = '0;
            else if (roll == 1)
                count = CFG_DATA_W'($urandom_range(17, 31));
            else if (roll == 2)
                count = 5'd1;
            else
                count = CFG_DATA_W'($urandom_range(2, 16));
            policy_data = ($urandom_range(0, 1) == 0) ? CFG_DATA_W'($urandom_range(0, 31))
                                                      : '0;
            policy_data[POLICY_W-1:0] = POLICY_W'($urandom_range(0, 3));
            set_config(policy_data, count);
            run_phase();
        end

        settle();
        if (sb.errors == 0)
            $display("[fixed_partition_fit_allocator] OK");
        else
            $display("[fixed_partition_fit_allocator] ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/fpfa_pkg.sv
rtl/core/fpfa_table.sv
rtl/core/fixed_partition_fit_allocator.sv
verif/testbench.sv
